// ----- sv/sgnms_pkg.sv -----
// Shared types and constants for the Sobel gradient / non-maximum suppression unit.
package sgnms_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int SIZE_W = 11;
  localparam int MAG_W = 21;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);

  // configuration register indexes
  localparam logic REG_IMAGE_WIDTH = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // direction sectors
  localparam logic [1:0] SEC_HORIZ = 2'd0;
  localparam logic [1:0] SEC_DIAG_UR = 2'd1;
  localparam logic [1:0] SEC_VERT = 2'd2;
  localparam logic [1:0] SEC_DIAG_UL = 2'd3;

  // one gradient point handed from front to back
  typedef struct packed {
    logic [MAG_W-1:0] msq;
    logic [1:0]       sector;
    logic             emit;
    logic             last;
    logic [COL_W-1:0] gc;
  } grad_item_t;

  // line buffer clearing sweep after reset
  typedef struct packed {
    logic             active;
    logic [COL_W-1:0] addr;
  } clr_t;

endpackage

// ----- sv/sgnms_front.sv -----
// Front end: counters, gray line buffer, pixel window, Sobel and sector classification.
module sgnms_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [10:0]             cfg_data,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [7:0]              in_tdata,
  input  sgnms_pkg::clr_t         clr,
  input  logic [sgnms_pkg::FIFO_AW:0] fifo_cnt,
  output logic                    push,
  output sgnms_pkg::grad_item_t   push_item
);
  import sgnms_pkg::*;

  logic [SIZE_W-1:0] width_r, height_r, w_eff, h_eff;
  logic [COL_W-1:0]  x_r;
  logic [ROW_W-1:0]  y_r;
  logic              acc, last_col, last_row;

  // stage 0: accepted pixel and line buffer read
  logic              v0_r, grad0_r, emit0_r, last0_r;
  logic [7:0]        p0_r;
  logic [COL_W-1:0]  x0_r;
  logic [15:0]       rd_r;
  logic [15:0]       gmem [0:MAX_WIDTH-1];
  logic [7:0]        pw_r [0:2][0:2];

  // stage 1: gradient components
  logic              v1_r, emit1_r, last1_r;
  logic [COL_W-1:0]  gc1_r;
  logic signed [10:0] gx_r, gy_r;
  logic signed [11:0] gx_c, gy_c;

  // stage 2: magnitude and sector
  logic [9:0]        a, b;
  logic [19:0]       asq, bsq;
  logic [MAG_W-1:0]  twob2;
  logic [10:0]       apb;
  logic [21:0]       apb2;
  logic [9:0]        amb;
  logic [19:0]       amb2;
  logic [1:0]        sec;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] hi);
    if (v < SIZE_W'(5)) return SIZE_W'(5);
    if (v > hi) return hi;
    return v;
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIZE_W'(640);
      height_r <= SIZE_W'(480);
    end else if (cfg_we) begin
      if (cfg_index == REG_IMAGE_WIDTH) width_r <= cfg_data;
      else height_r <= cfg_data;
    end
  end

  assign w_eff = clamp_size(width_r, SIZE_W'(MAX_WIDTH));
  assign h_eff = clamp_size(height_r, SIZE_W'(MAX_HEIGHT));

  // room for every item in flight ahead of the queue
  assign in_tready = !clr.active
                   && ((fifo_cnt + (FIFO_AW+1)'(v0_r) + (FIFO_AW+1)'(v1_r))
                       <= (FIFO_AW+1)'(FIFO_DEPTH - 1));
  assign acc = in_tvalid && in_tready;

  assign last_col = ({1'b0, x_r} + SIZE_W'(1)) >= w_eff;
  assign last_row = ({1'b0, y_r} + SIZE_W'(1)) >= h_eff;

  // raster counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      y_r <= '0;
    end else if (acc) begin
      if (last_col) begin
        x_r <= '0;
        y_r <= last_row ? '0 : y_r + ROW_W'(1);
      end else begin
        x_r <= x_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else v0_r <= acc;
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      p0_r    <= in_tdata;
      x0_r    <= x_r;
      grad0_r <= (y_r >= ROW_W'(2)) && (x_r >= COL_W'(2));
      emit0_r <= (y_r >= ROW_W'(4)) && (x_r >= COL_W'(4));
      last0_r <= last_col && last_row;
    end
  end

  // gray line buffer: low byte older row, high byte newer row
  always_ff @(posedge clk) begin
    if (clr.active) gmem[clr.addr] <= '0;
    else if (v0_r) gmem[x0_r] <= {p0_r, rd_r[15:8]};
    if (acc) rd_r <= gmem[x_r];
  end

  // pixel window shift
  always_ff @(posedge clk) begin
    if (v0_r) begin
      for (int r = 0; r < 3; r++) begin
        pw_r[r][0] <= pw_r[r][1];
        pw_r[r][1] <= pw_r[r][2];
      end
      pw_r[0][2] <= rd_r[7:0];
      pw_r[1][2] <= rd_r[15:8];
      pw_r[2][2] <= p0_r;
    end
  end

  // Sobel on the window as it stands after this shift
  always_comb begin
    gx_c = ($signed({4'b0, rd_r[7:0]}) + ($signed({4'b0, rd_r[15:8]}) <<< 1)
           + $signed({4'b0, p0_r}))
         - ($signed({4'b0, pw_r[0][1]}) + ($signed({4'b0, pw_r[1][1]}) <<< 1)
           + $signed({4'b0, pw_r[2][1]}));
    gy_c = ($signed({4'b0, pw_r[2][1]}) + ($signed({4'b0, pw_r[2][2]}) <<< 1)
           + $signed({4'b0, p0_r}))
         - ($signed({4'b0, pw_r[0][1]}) + ($signed({4'b0, pw_r[0][2]}) <<< 1)
           + $signed({4'b0, rd_r[7:0]}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= v0_r && grad0_r;
  end

  always_ff @(posedge clk) begin
    if (v0_r) begin
      gx_r    <= gx_c[10:0];
      gy_r    <= gy_c[10:0];
      emit1_r <= emit0_r;
      last1_r <= last0_r;
      gc1_r   <= x0_r - COL_W'(2);
    end
  end

  // squared magnitude and exact sector test
  always_comb begin
    logic [10:0] ngx, ngy;
    ngx   = -gx_r;
    ngy   = -gy_r;
    b     = gx_r[10] ? ngx[9:0] : gx_r[9:0];
    a     = gy_r[10] ? ngy[9:0] : gy_r[9:0];
    asq   = a * a;
    bsq   = b * b;
    twob2 = {bsq, 1'b0};
    apb   = {1'b0, a} + {1'b0, b};
    apb2  = apb * apb;
    amb   = a - b;
    amb2  = amb * amb;
    if (a == '0 || apb2 < {1'b0, twob2}) sec = SEC_HORIZ;
    else if (a > b && {1'b0, amb2} > twob2) sec = SEC_VERT;
    else if ((gx_r > 0) == (gy_r > 0)) sec = SEC_DIAG_UR;
    else sec = SEC_DIAG_UL;
    push_item.msq    = MAG_W'(asq) + MAG_W'(bsq);
    push_item.sector = sec;
    push_item.emit   = emit1_r;
    push_item.last   = last1_r;
    push_item.gc     = gc1_r;
  end

  assign push = v1_r;

endmodule

// ----- sv/sgnms_fifo.sv -----
// Short queue of gradient points between front and back.
module sgnms_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  sgnms_pkg::grad_item_t push_item,
  input  logic                  pop,
  output sgnms_pkg::grad_item_t pop_item,
  output logic                  empty,
  output logic [sgnms_pkg::FIFO_AW:0] cnt
);
  import sgnms_pkg::*;

  grad_item_t         q_r [0:FIFO_DEPTH-1];
  logic [FIFO_AW-1:0] wp_r, rp_r;
  logic [FIFO_AW:0]   cnt_r;
  logic               do_pop;

  assign empty  = (cnt_r == '0);
  assign do_pop = pop && !empty;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + FIFO_AW'(1);
      if (do_pop) rp_r <= rp_r + FIFO_AW'(1);
      cnt_r <= cnt_r + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= push_item;
  end

  assign pop_item = q_r[rp_r];
  assign cnt      = cnt_r;

endmodule

// ----- sv/sgnms_back.sv -----
// Back end: gradient line buffer, suppression window and pipelined square root.
module sgnms_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sgnms_pkg::clr_t       clr,
  input  sgnms_pkg::grad_item_t item,
  input  logic                  empty,
  output logic                  pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,
  output logic                  out_tlast
);
  import sgnms_pkg::*;

  localparam int G_W = MAG_W + 2;

  logic              en;
  logic              b0_v_r;
  grad_item_t        b0_r;
  logic [2*G_W-1:0]  rd_r;
  logic [2*G_W-1:0]  gmem [0:MAX_WIDTH-1];
  logic [G_W-1:0]    gw_r [0:2][0:2];
  logic [G_W-1:0]    g_new, ctr, n1, n2;
  logic [MAG_W-1:0]  cm;

  // square root pipeline, entry 0 fed by the suppression stage
  logic              sq_v_r   [0:8];
  logic              sq_l_r   [0:8];
  logic [15:0]       sq_val_r [0:8];
  logic [7:0]        sq_rt_r  [0:8];
  logic [15:0]       sq_rsq_r [0:8];

  assign en  = !sq_v_r[8] || out_tready;
  assign pop = en && !empty;

  // stage B0: pop and line buffer read
  always_ff @(posedge clk) begin
    if (!rst_n) b0_v_r <= 1'b0;
    else if (en) b0_v_r <= !empty;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b0_r <= item;
      rd_r <= gmem[item.gc];
    end
    if (clr.active) gmem[clr.addr] <= '0;
    else if (en && b0_v_r) gmem[b0_r.gc] <= {g_new, rd_r[2*G_W-1:G_W]};
  end

  assign g_new = {b0_r.sector, b0_r.msq};

  // window shift
  always_ff @(posedge clk) begin
    if (en && b0_v_r) begin
      for (int r = 0; r < 3; r++) begin
        gw_r[r][0] <= gw_r[r][1];
        gw_r[r][1] <= gw_r[r][2];
      end
      gw_r[0][2] <= rd_r[G_W-1:0];
      gw_r[1][2] <= rd_r[2*G_W-1:G_W];
      gw_r[2][2] <= g_new;
    end
  end

  // neighbours along the centre's sector, in the shifted window
  always_comb begin
    ctr = gw_r[1][2];
    case (ctr[G_W-1:MAG_W])
      SEC_HORIZ: begin
        n1 = gw_r[1][1];
        n2 = rd_r[2*G_W-1:G_W];
      end
      SEC_DIAG_UR: begin
        n1 = rd_r[G_W-1:0];
        n2 = gw_r[2][1];
      end
      SEC_VERT: begin
        n1 = gw_r[0][2];
        n2 = gw_r[2][2];
      end
      default: begin
        n1 = gw_r[0][1];
        n2 = g_new;
      end
    endcase
    cm = ctr[MAG_W-1:0];
  end

  // suppression result; magnitudes past 16 bits clamp so the root saturates
  always_ff @(posedge clk) begin
    if (!rst_n) sq_v_r[0] <= 1'b0;
    else if (en) sq_v_r[0] <= b0_v_r && b0_r.emit;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_l_r[0]   <= b0_r.last;
      sq_rt_r[0]  <= '0;
      sq_rsq_r[0] <= '0;
      if (cm < n1[MAG_W-1:0] || cm < n2[MAG_W-1:0]) sq_val_r[0] <= '0;
      else if (cm[MAG_W-1:16] != '0) sq_val_r[0] <= 16'hFFFF;
      else sq_val_r[0] <= cm[15:0];
    end
  end

  // one root bit per stage, most significant first
  for (genvar s = 0; s < 8; s++) begin : g_sqrt
    localparam int BIT = 7 - s;
    logic [16:0] trial;
    assign trial = {1'b0, sq_rsq_r[s]} + (17'(sq_rt_r[s]) << (BIT + 1))
                 + (17'd1 << (2 * BIT));

    always_ff @(posedge clk) begin
      if (!rst_n) sq_v_r[s+1] <= 1'b0;
      else if (en) sq_v_r[s+1] <= sq_v_r[s];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_l_r[s+1]   <= sq_l_r[s];
        sq_val_r[s+1] <= sq_val_r[s];
        if (trial <= {1'b0, sq_val_r[s]}) begin
          sq_rt_r[s+1]  <= sq_rt_r[s] | 8'(1 << BIT);
          sq_rsq_r[s+1] <= trial[15:0];
        end else begin
          sq_rt_r[s+1]  <= sq_rt_r[s];
          sq_rsq_r[s+1] <= sq_rsq_r[s];
        end
      end
    end
  end

  assign out_tvalid = sq_v_r[8];
  assign out_tdata  = sq_rt_r[8];
  assign out_tlast  = sq_l_r[8];

endmodule

// ----- sv/sobel_gradient_nonmax_suppress_unit.sv -----
// Top level of the Sobel gradient / non-maximum suppression unit.
// Throughput: one pixel per cycle, less whenever the result side stalls.
// Reset: synchronous, active low; then a sweep clears both line buffers with
// in_tready low; configuration writes are taken throughout.
module sobel_gradient_nonmax_suppress_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] gray_pixel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] edge_strength
  output logic        out_tlast   // frame_last
);
  import sgnms_pkg::*;

  logic [COL_W:0]   clr_cnt_r;
  clr_t             clr;
  logic             push, pop, empty;
  logic [FIFO_AW:0] fifo_cnt;
  grad_item_t       push_item, pop_item;

  // clearing sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) clr_cnt_r <= '0;
    else if (!clr_cnt_r[COL_W]) clr_cnt_r <= clr_cnt_r + (COL_W+1)'(1);
  end

  assign clr.active = !clr_cnt_r[COL_W];
  assign clr.addr   = clr_cnt_r[COL_W-1:0];

  sgnms_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_tvalid, .in_tready, .in_tdata,
    .clr, .fifo_cnt, .push, .push_item
  );

  sgnms_fifo u_fifo (
    .clk, .rst_n, .push, .push_item, .pop, .pop_item, .empty, .cnt(fifo_cnt)
  );

  sgnms_back u_back (
    .clk, .rst_n, .clr, .item(pop_item), .empty, .pop,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );

endmodule

// ----- sv/sgnms_checker.sv -----
// Port-level checks on the top level, with the bind that attaches them.
module sgnms_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // reset starts the buffer sweep, so no pixel is taken next cycle
  a_no_take_after_reset: assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("pixel taken right after reset");

  // reset flushes every result in flight
  a_no_result_after_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result shown right after reset");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  // and keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

endmodule

bind sobel_gradient_nonmax_suppress_unit sgnms_checker u_checker (
  .clk, .rst_n, .in_tready, .out_tvalid, .out_tready, .out_tdata, .out_tlast
);
